@@ hdl/hsv2rgb_pkg.sv @@
// Shared types and constants of the HSV to RGB converter.
package hsv2rgb_pkg;

   localparam int HUE_W = 18;
   localparam int BYTE_W = 8;
   localparam int HUE_SCALE_DEF = 512;
   // Sector register plus level-pipeline stages plus output register.
   localparam int NUM_STAGES = 6;

   // Hue sector, sixty degrees each.
   typedef enum logic [2:0] {
      SEC_R_TO_Y = 3'd0,
      SEC_Y_TO_G = 3'd1,
      SEC_G_TO_C = 3'd2,
      SEC_C_TO_B = 3'd3,
      SEC_B_TO_M = 3'd4,
      SEC_M_TO_R = 3'd5
   } sector_type;

   // Per-pixel side data that rides along with the level pipeline.
   typedef struct packed {
      sector_type          sector;
      logic                grey;
      logic [BYTE_W-1:0]   value;
      logic [BYTE_W-1:0]   low;
   } side_type;

endpackage

@@ hdl/hsv2rgb_sector.sv @@
// First stage: hue clamp, sector search, in-sector offset and low level.
module hsv2rgb_sector #(
   parameter int HUE_SCALE = hsv2rgb_pkg::HUE_SCALE_DEF,
   parameter int FW = $clog2(60 * HUE_SCALE + 1)
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue,
   input  logic [hsv2rgb_pkg::BYTE_W-1:0]      saturation,
   input  logic [hsv2rgb_pkg::BYTE_W-1:0]      brightness,
   output logic [FW-1:0]                       fall_ff,
   output logic [FW-1:0]                       rise_ff,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]      sat_ff,
   output hsv2rgb_pkg::side_type               side_ff
);

   localparam int SPAN = 60 * HUE_SCALE;
   localparam logic [31:0] HUE_TOP = 32'(360 * HUE_SCALE - 1);
   localparam logic [31:0] SPAN_32 = 32'(SPAN);

   logic [31:0]                      hue_ext;
   logic [hsv2rgb_pkg::HUE_W-1:0]    hue_c;
   logic [31:0]                      base;
   logic [31:0]                      diff;
   logic [16:0]                      low_prod;
   hsv2rgb_pkg::sector_type          sector;
   logic [FW-1:0]                    fall_in;
   logic [FW-1:0]                    rise_in;
   hsv2rgb_pkg::side_type            side_in;

   always_comb begin
      hue_ext = 32'(hue);
      // clamp to the last representable hue below 360 degrees
      hue_c = (hue_ext > HUE_TOP) ? HUE_TOP[hsv2rgb_pkg::HUE_W-1:0] : hue;

      if (32'(hue_c) >= 5 * SPAN_32) begin
         sector = hsv2rgb_pkg::SEC_M_TO_R;
      end else if (32'(hue_c) >= 4 * SPAN_32) begin
         sector = hsv2rgb_pkg::SEC_B_TO_M;
      end else if (32'(hue_c) >= 3 * SPAN_32) begin
         sector = hsv2rgb_pkg::SEC_C_TO_B;
      end else if (32'(hue_c) >= 2 * SPAN_32) begin
         sector = hsv2rgb_pkg::SEC_G_TO_C;
      end else if (32'(hue_c) >= SPAN_32) begin
         sector = hsv2rgb_pkg::SEC_Y_TO_G;
      end else begin
         sector = hsv2rgb_pkg::SEC_R_TO_Y;
      end

      case (sector)
         hsv2rgb_pkg::SEC_R_TO_Y: base = 32'd0;
         hsv2rgb_pkg::SEC_Y_TO_G: base = SPAN_32;
         hsv2rgb_pkg::SEC_G_TO_C: base = 2 * SPAN_32;
         hsv2rgb_pkg::SEC_C_TO_B: base = 3 * SPAN_32;
         hsv2rgb_pkg::SEC_B_TO_M: base = 4 * SPAN_32;
         default:                 base = 5 * SPAN_32;
      endcase

      diff = 32'(hue_c) - base;
      fall_in = diff[FW-1:0];
      rise_in = FW'(SPAN) - fall_in;

      low_prod = 17'(brightness) * (17'd256 - 17'(saturation));

      side_in.sector = sector;
      side_in.grey   = (saturation == '0);
      side_in.value  = brightness;
      side_in.low    = low_prod[15:8];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fall_ff <= fall_in;
         rise_ff <= rise_in;
         sat_ff  <= saturation;
         side_ff <= side_in;
      end
   end

endmodule

@@ hdl/hsv2rgb_level.sv @@
// Four-stage pipeline: ceil(x*s*v / (256*span)) by products and a reciprocal.
module hsv2rgb_level #(
   parameter int HUE_SCALE = hsv2rgb_pkg::HUE_SCALE_DEF,
   parameter int FW = $clog2(60 * HUE_SCALE + 1)
) (
   input  logic                                clock,
   input  logic [3:0]                          en,
   input  logic [FW-1:0]                       x,
   input  logic [hsv2rgb_pkg::BYTE_W-1:0]      sat,
   input  logic [hsv2rgb_pkg::BYTE_W-1:0]      value,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]      quot
);

   localparam int SPAN = 60 * HUE_SCALE;
   localparam int CW = $clog2(257 * SPAN);
   localparam int RECIP = (2 ** CW) / SPAN;
   localparam int MW = $clog2(RECIP + 1);
   localparam logic [CW-1:0] SPAN_C = CW'(SPAN);
   localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

   logic [FW+7:0]         xs_ff;
   logic [FW+7:0]         xs_in;
   logic [FW+15:0]        b_ff;
   logic [FW+15:0]        b_in;
   logic [FW+16:0]        b_round;
   logic [CW-1:0]         c_in;
   logic [CW-1:0]         c_ff;
   logic [CW+MW-1:0]      est_prod;
   logic [7:0]            est_in;
   logic [CW-1:0]         back;
   logic [CW-1:0]         c4_ff;
   logic [7:0]            est4_ff;
   logic [CW-1:0]         rem;

   always_comb begin
      xs_in = (FW+8)'(x) * (FW+8)'(sat);
      b_in = (FW+16)'(xs_ff) * (FW+16)'(value);
      // ceil by 256 first, then bias for ceil by span
      b_round = (FW+17)'(b_ff) + (FW+17)'(255);
      c_in = CW'(b_round >> 8) + SPAN_C - CW'(1);
      // estimate is exact or one low
      est_prod = (CW+MW)'(c_ff) * (CW+MW)'(RECIP_C);
      est_in = est_prod[CW+7:CW];
      // bump the estimate when a whole span is left over
      back = CW'(est4_ff) * SPAN_C;
      rem = c4_ff - back;
      quot = (rem >= SPAN_C) ? est4_ff + 8'd1 : est4_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         xs_ff <= xs_in;
      end
      if (en[1]) begin
         b_ff <= b_in;
      end
      if (en[2]) begin
         c_ff <= c_in;
      end
      if (en[3]) begin
         c4_ff   <= c_ff;
         est4_ff <= est_in;
      end
   end

endmodule

@@ hdl/hsv2rgb_route.sv @@
// Output stage: form falling and rising levels and route them by sector.
module hsv2rgb_route (
   input  logic                                clock,
   input  logic                                en,
   input  hsv2rgb_pkg::side_type               side,
   input  logic [hsv2rgb_pkg::BYTE_W-1:0]      fall_cut,
   input  logic [hsv2rgb_pkg::BYTE_W-1:0]      rise_cut,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]      red_ff,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]      green_ff,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]      blue_ff
);

   logic [hsv2rgb_pkg::BYTE_W-1:0] fall;
   logic [hsv2rgb_pkg::BYTE_W-1:0] rise;
   logic [hsv2rgb_pkg::BYTE_W-1:0] red_in;
   logic [hsv2rgb_pkg::BYTE_W-1:0] green_in;
   logic [hsv2rgb_pkg::BYTE_W-1:0] blue_in;

   always_comb begin
      fall = side.value - fall_cut;
      rise = side.value - rise_cut;
      if (side.grey) begin
         red_in   = side.value;
         green_in = side.value;
         blue_in  = side.value;
      end else begin
         case (side.sector)
            hsv2rgb_pkg::SEC_R_TO_Y: begin
               red_in = side.value; green_in = rise;       blue_in = side.low;
            end
            hsv2rgb_pkg::SEC_Y_TO_G: begin
               red_in = fall;       green_in = side.value; blue_in = side.low;
            end
            hsv2rgb_pkg::SEC_G_TO_C: begin
               red_in = side.low;   green_in = side.value; blue_in = rise;
            end
            hsv2rgb_pkg::SEC_C_TO_B: begin
               red_in = side.low;   green_in = fall;       blue_in = side.value;
            end
            hsv2rgb_pkg::SEC_B_TO_M: begin
               red_in = rise;       green_in = side.low;   blue_in = side.value;
            end
            default: begin
               red_in = side.value; green_in = side.low;   blue_in = fall;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

endmodule

@@ hdl/hsv_to_rgb_integer.sv @@
// Top level of the pipelined integer HSV to RGB pixel converter.
//
//   channel   direction   tdata fields (low bit first)
//   req_      in          hue[17:0], saturation[25:18], brightness[33:26], zero[39:34]
//   rsp_      out         red[7:0], green[15:8], blue[23:16]
//
// One pixel per clock in steady state while the result side accepts; each pixel
// passes the sector stage, four level stages and the output register.
// Every stage can load in every cycle, so a new pixel can enter each clock.
// Reset clears only the valid bits; payload registers are left as they are.
// Each stage advances when it is empty or the stage after it advances, so a
// held result stalls only the occupied stages and bubbles still fill behind.
module hsv_to_rgb_integer #(
   parameter int HUE_SCALE = hsv2rgb_pkg::HUE_SCALE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // hue[17:0], saturation[25:18], brightness[33:26]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   localparam int FW = $clog2(60 * HUE_SCALE + 1);
   localparam int NS = hsv2rgb_pkg::NUM_STAGES;

   logic [NS-1:0]                       vld_ff;
   logic [NS-1:0]                       vld_in;
   logic [NS:0]                         rdy;
   logic [FW-1:0]                       fall_x;
   logic [FW-1:0]                       rise_x;
   logic [hsv2rgb_pkg::BYTE_W-1:0]      sat_s0;
   hsv2rgb_pkg::side_type               side_s0;
   hsv2rgb_pkg::side_type               side_ff [1:4];
   logic [hsv2rgb_pkg::BYTE_W-1:0]      fall_cut;
   logic [hsv2rgb_pkg::BYTE_W-1:0]      rise_cut;
   logic [hsv2rgb_pkg::BYTE_W-1:0]      red;
   logic [hsv2rgb_pkg::BYTE_W-1:0]      green;
   logic [hsv2rgb_pkg::BYTE_W-1:0]      blue;

   // Ready ripples back: a stage loads when empty or when its successor loads.
   always_comb begin
      rdy[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {blue, green, red};

   hsv2rgb_sector #(.HUE_SCALE(HUE_SCALE), .FW(FW)) u_sector (
      .clock      (clock),
      .en         (rdy[0]),
      .hue        (req_tdata[17:0]),
      .saturation (req_tdata[25:18]),
      .brightness (req_tdata[33:26]),
      .fall_ff    (fall_x),
      .rise_ff    (rise_x),
      .sat_ff     (sat_s0),
      .side_ff    (side_s0)
   );

   // Hold side data alongside the level pipelines.
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         side_ff[1] <= side_s0;
      end
      for (int k = 2; k <= 4; k++) begin
         if (rdy[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Falling level cut: ceil(f*s*v / (256*span)).
   hsv2rgb_level #(.HUE_SCALE(HUE_SCALE), .FW(FW)) u_level_fall (
      .clock (clock),
      .en    (rdy[4:1]),
      .x     (fall_x),
      .sat   (sat_s0),
      .value (side_ff[1].value),
      .quot  (fall_cut)
   );

   // Rising level cut: ceil((span-f)*s*v / (256*span)).
   hsv2rgb_level #(.HUE_SCALE(HUE_SCALE), .FW(FW)) u_level_rise (
      .clock (clock),
      .en    (rdy[4:1]),
      .x     (rise_x),
      .sat   (sat_s0),
      .value (side_ff[1].value),
      .quot  (rise_cut)
   );

   hsv2rgb_route u_route (
      .clock    (clock),
      .en       (rdy[5]),
      .side     (side_ff[4]),
      .fall_cut (fall_cut),
      .rise_cut (rise_cut),
      .red_ff   (red),
      .green_ff (green),
      .blue_ff  (blue)
   );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of the pipelined integer HSV to RGB pixel converter.
module tb_top;

   // Hue scale of the instance and the derived sector geometry.
   localparam int unsigned SCALE = hsv2rgb_pkg::HUE_SCALE_DEF;
   localparam int unsigned SECTOR_SPAN = 60 * SCALE;
   localparam int unsigned HUE_TOP = 360 * SCALE - 1;
   localparam int RANDOM_PIXELS = 1500;
   localparam int NUM_PHASES = 4;
   localparam int LONG_HOLD = 400;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [hsv2rgb_pkg::HUE_W-1:0]  hue;
      logic [hsv2rgb_pkg::BYTE_W-1:0] sat;
      logic [hsv2rgb_pkg::BYTE_W-1:0] val;
   } hsv_pixel_type;

   typedef struct {
      logic [hsv2rgb_pkg::BYTE_W-1:0] red;
      logic [hsv2rgb_pkg::BYTE_W-1:0] green;
      logic [hsv2rgb_pkg::BYTE_W-1:0] blue;
   } rgb_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // hue[17:0], saturation[25:18], brightness[33:26]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // red[7:0], green[15:8], blue[23:16]

   // Pixels waiting to be offered; the head is the one on the bus while valid is high.
   hsv_pixel_type  pending_px[$];
   // Colors predicted for accepted pixels, oldest first.
   rgb_pixel_type  expected_rgb[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_arm = 1'b0;
   logic        hold_used = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned pixels_in = 0;
   int unsigned colors_out = 0;
   int unsigned grey_pixels = 0;
   int unsigned clamped_pixels = 0;

   hsv_to_rgb_integer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Integer HSV to RGB conversion: clamp the hue, return grey for zero saturation, find the
   // sector, form the low, falling and rising levels with truncating division, then route.
   function automatic rgb_pixel_type convert_hsv(hsv_pixel_type px);
      longint unsigned h, s, v, sec, f, den, lvl_low, lvl_fall, lvl_rise;
      hsv2rgb_pkg::sector_type sector;
      rgb_pixel_type c;
      h = px.hue;
      s = px.sat;
      v = px.val;
      if (h > HUE_TOP) begin
         h = HUE_TOP;
      end
      if (s == 0) begin
         c.red = v[7:0];
         c.green = v[7:0];
         c.blue = v[7:0];
         return c;
      end
      sec = h / SECTOR_SPAN;
      f = h - sec * SECTOR_SPAN;
      den = 256 * SECTOR_SPAN;
      lvl_low = (v * (256 - s)) / 256;
      lvl_fall = (den * v - f * s * v) / den;
      lvl_rise = (den * v - (SECTOR_SPAN - f) * s * v) / den;
      sector = hsv2rgb_pkg::sector_type'(sec[2:0]);
      case (sector)
         hsv2rgb_pkg::SEC_R_TO_Y: begin
            c.red = v[7:0]; c.green = lvl_rise[7:0]; c.blue = lvl_low[7:0];
         end
         hsv2rgb_pkg::SEC_Y_TO_G: begin
            c.red = lvl_fall[7:0]; c.green = v[7:0]; c.blue = lvl_low[7:0];
         end
         hsv2rgb_pkg::SEC_G_TO_C: begin
            c.red = lvl_low[7:0]; c.green = v[7:0]; c.blue = lvl_rise[7:0];
         end
         hsv2rgb_pkg::SEC_C_TO_B: begin
            c.red = lvl_low[7:0]; c.green = lvl_fall[7:0]; c.blue = v[7:0];
         end
         hsv2rgb_pkg::SEC_B_TO_M: begin
            c.red = lvl_rise[7:0]; c.green = lvl_low[7:0]; c.blue = v[7:0];
         end
         default: begin
            c.red = v[7:0]; c.green = lvl_low[7:0]; c.blue = lvl_fall[7:0];
         end
      endcase
      return c;
   endfunction

   // Driver: predict on each accepted transfer, then offer the next pixel
   // unless the sender idles this cycle. Hold the bus while it is stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rgb.push_back(convert_hsv(pending_px[0]));
            if (pending_px[0].sat == 0) grey_pixels++;
            if (pending_px[0].hue > HUE_TOP) clamped_pixels++;
            pixels_in++;
            void'(pending_px.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (pending_px.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, pending_px[0].val, pending_px[0].sat, pending_px[0].hue};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off of the result side, armed once; the sender keeps going so
   // the pipeline fills and backs up into the request side.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_arm && !hold_used) begin
         hold_left <= LONG_HOLD;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: compare each accepted result with the oldest prediction,
   // then pick the ready level for the next cycle.
   always @(posedge clock) begin
      rgb_pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            colors_out++;
            if (expected_rgb.size() == 0) begin
               $error("unexpected result transfer: rsp_tdata = %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_tdata[7:0] !== want.red) begin
                  $error("red mismatch: expected %0d, got %0d", want.red, rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tdata[15:8] !== want.green) begin
                  $error("green mismatch: expected %0d, got %0d",
                         want.green, rsp_tdata[15:8]);
                  error_count++;
               end
               if (rsp_tdata[23:16] !== want.blue) begin
                  $error("blue mismatch: expected %0d, got %0d",
                         want.blue, rsp_tdata[23:16]);
                  error_count++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run if traffic stops moving.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached with %0d results outstanding",
                  CYCLE_LIMIT, expected_rgb.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic queue_pixel(int unsigned hue, int unsigned sat, int unsigned val);
      hsv_pixel_type px;
      px.hue = hue[hsv2rgb_pkg::HUE_W-1:0];
      px.sat = sat[hsv2rgb_pkg::BYTE_W-1:0];
      px.val = val[hsv2rgb_pkg::BYTE_W-1:0];
      pending_px.push_back(px);
   endtask

   // Random pixel: mostly in-range hues, some right at sector edges, some above
   // the top of the range; saturation and brightness with extra weight on ends.
   task automatic queue_random_pixel();
      int unsigned hue, sat, val, pick;
      pick = $urandom_range(99);
      if (pick < 65) begin
         hue = $urandom_range(HUE_TOP);
      end else if (pick < 80) begin
         hue = $urandom_range(5, 1) * SECTOR_SPAN + $urandom_range(4) - 2;
      end else begin
         hue = $urandom_range((1 << hsv2rgb_pkg::HUE_W) - 1, HUE_TOP + 1);
      end
      pick = $urandom_range(99);
      sat = (pick < 10) ? 0 : (pick < 20) ? 255 : $urandom_range(255);
      pick = $urandom_range(99);
      val = (pick < 5) ? 0 : (pick < 15) ? 255 : $urandom_range(255);
      queue_pixel(hue, sat, val);
   endtask

   task automatic wait_drained();
      while (pending_px.size() != 0 || expected_rgb.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: range ends, every sector edge, grey, clamped hues.
      queue_pixel(0, 0, 0);
      queue_pixel(0, 255, 255);
      queue_pixel(SECTOR_SPAN - 1, 255, 255);
      queue_pixel(SECTOR_SPAN, 255, 255);
      queue_pixel(2 * SECTOR_SPAN - 1, 255, 255);
      queue_pixel(2 * SECTOR_SPAN, 255, 255);
      queue_pixel(3 * SECTOR_SPAN, 255, 255);
      queue_pixel(4 * SECTOR_SPAN, 255, 255);
      queue_pixel(5 * SECTOR_SPAN, 255, 255);
      queue_pixel(HUE_TOP, 255, 255);
      queue_pixel(HUE_TOP + 1, 255, 255);
      queue_pixel((1 << hsv2rgb_pkg::HUE_W) - 1, 1, 255);
      queue_pixel((1 << hsv2rgb_pkg::HUE_W) - 1, 0, 0);
      queue_pixel(SECTOR_SPAN / 2, 1, 255);
      queue_pixel(SECTOR_SPAN / 2, 255, 1);
      queue_pixel(100000, 0, 200);
      queue_pixel(45000, 128, 128);
      queue_pixel(150000, 77, 200);
      queue_pixel(110000, 255, 0);
      queue_pixel(170000, 254, 254);
      wait_drained();

      // Random phases: free flow (with the long hold-off), sender idling,
      // receiver stalling, then both.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_arm = 1'b1; end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         repeat (RANDOM_PIXELS / NUM_PHASES) queue_random_pixel();
         wait_drained();
      end

      repeat (hsv2rgb_pkg::NUM_STAGES * 4) @(negedge clock);
      $display("converted %0d pixels (%0d grey, %0d with clamped hue), %0d colors checked",
               pixels_in, grey_pixels, clamped_pixels, colors_out);
      $display("flow control: free flow, long result hold-off, idle sender and receiver");
      if (error_count == 0 && expected_rgb.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_sector.sv
hdl/hsv2rgb_level.sv
hdl/hsv2rgb_route.sv
hdl/hsv_to_rgb_integer.sv
verif/tb_top.sv
